// ===== rtl/sca_pkg.sv =====
package sca_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_ROOT = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_NEGROOT = 3'd4,
        ST_SAT     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_DECIDE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_ROOT,
        S_FIN,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [4:0]         depth;
        logic [2:0]         status;
    } out_item_t;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;

endpackage

// ===== rtl/stack_calculator_alu_core.sv =====
// RPN operand stack with a Q16.16 arithmetic unit. One item is processed at a time.
// Its result waits in an output register, and the block takes the next item in the cycle
// after that register is loaded, whether or not the result has been taken yet.
// Push, unused commands and items ending in underflow, overflow, divide-by-zero or
// negative-root status go from the read states straight to the write state. Add and
// subtract pass the final state first; multiply, divide and square root also pass their
// own states before it. Each item reads the top two entries from a synchronous memory
// with a registered read, then writes at most one entry back. Divide and square root use
// a radix-2 restoring recurrence that retires one bit per cycle: 48 quotient bits or 24
// root bits. A result that is still waiting when the next one is ready holds the block.
module stack_calculator_alu_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sca_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sca_pkg::out_item_t  out_data
);
    import sca_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    state_t state_reg, state_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] l_reg, l_next;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] aux_reg, aux_next;
    logic [49:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] top_reg, top_next;
    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;

    logic [31:0] mag_l, mag_r;
    logic [49:0] trial;
    logic [47:0] dshift;
    logic [32:0] sum;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign mag_l = l_reg[31] ? (~l_reg + 32'd1) : l_reg;
    assign mag_r = r_reg[31] ? (~r_reg + 32'd1) : r_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid && !in_stall) state_next = S_RD1;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_DECIDE;
            S_DECIDE: state_next = S_FIN;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_FIN;
            S_DIV:    if (cnt_reg == 6'd0) state_next = S_FIN;
            S_ROOT:   if (cnt_reg == 6'd0) state_next = S_FIN;
            S_FIN:    state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    if (!ov_reg || !out_stall) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        if (state_reg == S_DECIDE)
        begin
            state_next = S_WRITE;
            if (st_reg == ST_OK)
            begin
                case (cmd_reg)
                    CMD_ADD, CMD_SUB: state_next = S_FIN;
                    CMD_MUL:          state_next = S_MUL1;
                    CMD_DIV:          state_next = (r_reg == 32'd0) ? S_WRITE : S_DIV;
                    CMD_ROOT:         state_next = l_reg[31] ? S_WRITE : S_ROOT;
                    default:          state_next = S_WRITE;
                endcase
            end
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        cmd_next = cmd_reg;
        opnd_next = opnd_reg;
        r_next = r_reg;
        l_next = l_reg;
        acc_next = acc_reg;
        aux_next = aux_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        st_next = st_reg;
        res_next = res_reg;
        top_next = top_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = res_reg;
        trial = '0;
        dshift = '0;
        sum = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cmd_next = in_data.cmd;
                opnd_next = in_data.operand;
                st_next = ST_OK;
                rd_addr = AW'(sp_reg - PW'(1));
            end
            S_RD1:
            begin
                rd_addr = AW'(sp_reg - PW'(2));
                r_next = rd_data;
                l_next = rd_data;
                top_next = (sp_reg == '0) ? 32'd0 : rd_data;
            end
            S_RD2:
            begin
                if (cmd_reg != CMD_ROOT) l_next = rd_data;
                case (cmd_reg)
                    CMD_PUSH:
                        st_next = (sp_reg >= PW'(STACK_DEPTH)) ? ST_OVER : ST_OK;
                    CMD_ROOT:
                        st_next = (sp_reg < PW'(1)) ? ST_UNDER : ST_OK;
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        st_next = (sp_reg < PW'(2)) ? ST_UNDER : ST_OK;
                    default: st_next = ST_OK;
                endcase
            end
            S_DECIDE:
            begin
                neg_next = l_reg[31] ^ r_reg[31];
                if (cmd_reg == CMD_DIV && st_reg == ST_OK && r_reg == 32'd0)
                    st_next = ST_DIVZERO;
                if (cmd_reg == CMD_ROOT && st_reg == ST_OK && l_reg[31])
                    st_next = ST_NEGROOT;
                acc_next = {mag_l, 16'd0};
                aux_next = 48'd0;
                rem_next = '0;
                cnt_next = (cmd_reg == CMD_DIV) ? 6'd47 : 6'd23;
                if (cmd_reg == CMD_ROOT) acc_next = {l_reg, 16'd0};
                if (cmd_reg != CMD_ROOT) aux_next[31:0] = mag_r;
            end
            S_MUL1:
            begin
                acc_next = {16'd0, mag_l[15:0]} * {16'd0, mag_r};
                aux_next = {16'd0, {16'd0, mag_l[31:16]} * {16'd0, mag_r[15:0]}};
                rem_next = {18'd0, {16'd0, mag_l[31:16]} * {16'd0, mag_r[31:16]}};
            end
            S_MUL2:
            begin
                acc_next = (acc_reg >> 16) + (aux_reg[47:0]);
                rem_next = rem_reg;
            end
            S_DIV:
            begin
                dshift = {acc_reg[46:0], 1'b0};
                trial = {rem_reg[48:0], acc_reg[47]} - {18'd0, aux_reg[31:0]};
                if (!trial[49])
                begin
                    rem_next = trial;
                    acc_next = {dshift[47:1], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[48:0], acc_reg[47]};
                    acc_next = dshift;
                end
                cnt_next = cnt_reg - 6'd1;
            end
            S_ROOT:
            begin
                trial = {rem_reg[47:0], acc_reg[47:46]}
                      - {aux_reg[47:0], 2'b01};
                acc_next = {acc_reg[45:0], 2'b00};
                if (!trial[49])
                begin
                    rem_next = trial;
                    aux_next = {aux_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[47:0], acc_reg[47:46]};
                    aux_next = {aux_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
            S_FIN:
            begin
                case (cmd_reg)
                    CMD_ADD, CMD_SUB:
                    begin
                        sum = (cmd_reg == CMD_ADD)
                            ? {l_reg[31], l_reg} + {r_reg[31], r_reg}
                            : {l_reg[31], l_reg} - {r_reg[31], r_reg};
                        res_next = sum[31:0];
                        if (sum[32] != sum[31])
                        begin
                            res_next = sum[32] ? MAX_NEG : MAX_POS;
                            st_next = ST_SAT;
                        end
                    end
                    CMD_ROOT:
                        res_next = aux_reg[31:0];
                    default:
                    begin
                        if (cmd_reg == CMD_MUL)
                            dshift = acc_reg + {rem_reg[31:0], 16'd0};
                        else
                            dshift = acc_reg;
                        if (!neg_reg && dshift > 48'h7FFF_FFFF)
                        begin
                            res_next = MAX_POS;
                            st_next = ST_SAT;
                        end
                        else if (neg_reg && dshift > 48'h8000_0000)
                        begin
                            res_next = MAX_NEG;
                            st_next = ST_SAT;
                        end
                        else
                            res_next = neg_reg ? (~dshift[31:0] + 32'd1) : dshift[31:0];
                        if (cmd_reg == CMD_MUL && (rem_reg[31:16] != 16'd0))
                        begin
                            res_next = neg_reg ? MAX_NEG : MAX_POS;
                            st_next = ST_SAT;
                        end
                    end
                endcase
            end
            S_WRITE:
            begin
                if (cmd_reg == CMD_PUSH && st_reg == ST_OK)
                begin
                    wr_en = 1'b1;
                    wr_addr = AW'(sp_reg);
                    wr_data = opnd_reg;
                    sp_next = sp_reg + PW'(1);
                    top_next = opnd_reg;
                end
                else if ((st_reg == ST_OK || st_reg == ST_SAT)
                         && cmd_reg >= CMD_ADD && cmd_reg <= CMD_ROOT)
                begin
                    wr_en = 1'b1;
                    wr_data = res_reg;
                    top_next = res_reg;
                    if (cmd_reg == CMD_ROOT)
                        wr_addr = AW'(sp_reg - PW'(1));
                    else
                    begin
                        wr_addr = AW'(sp_reg - PW'(2));
                        sp_next = sp_reg - PW'(1);
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.top_value = top_reg;
                    od_next.depth = 5'(sp_reg);
                    od_next.status = st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        opnd_reg <= opnd_next;
        r_reg <= r_next;
        l_reg <= l_next;
        acc_reg <= acc_next;
        aux_reg <= aux_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        st_reg <= st_next;
        res_reg <= res_next;
        top_reg <= top_next;
        od_reg <= od_next;
    end

`ifndef NO_ASSERTIONS
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("item taken while busy");
    a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE) |=> $stable(sp_reg)) else $error("pointer moved");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled item changed");
`endif

endmodule

// ===== bench/stack_calculator_alu_core_tb.sv =====
`timescale 1ns / 100ps

module stack_calculator_alu_core_tb;

    import sca_pkg::*;

    localparam int DEPTH_MAX  = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    logic [31:0] calc_stack[DEPTH_MAX];
    int        calc_depth;
    int        error_count;
    int        idle_cycles;
    int        send_gap;
    int        recv_gap;
    bit        sending_done;
    bit        hold_sender;
    bit        in_accepted;

    stack_calculator_alu_core #(.STACK_DEPTH(DEPTH_MAX)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] clamp_q(input logic signed [63:0] v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return MAX_POS;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return MAX_NEG;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic out_item_t calc_step(input in_item_t item);
        out_item_t o;
        logic signed [63:0] l;
        logic signed [63:0] r;
        logic [63:0] ml;
        logic [63:0] mr;
        logic signed [63:0] v;
        logic [31:0] res;
        status_t st;
        bit sat;
        bit neg;
        st = ST_OK;
        sat = 1'b0;
        if (item.cmd == CMD_PUSH)
        begin
            if (calc_depth >= DEPTH_MAX)
                st = ST_OVER;
            else
            begin
                calc_stack[calc_depth] = item.operand;
                calc_depth++;
            end
        end
        else if (item.cmd == CMD_ROOT)
        begin
            if (calc_depth < 1)
                st = ST_UNDER;
            else if (calc_stack[calc_depth-1][31])
                st = ST_NEGROOT;
            else
            begin
                ml = {32'd0, calc_stack[calc_depth-1]} << 16;
                calc_stack[calc_depth-1] = 32'(int_sqrt(ml));
            end
        end
        else if (item.cmd >= CMD_ADD && item.cmd <= CMD_DIV)
        begin
            if (calc_depth < 2)
                st = ST_UNDER;
            else
            begin
                r = $signed(calc_stack[calc_depth-1]);
                l = $signed(calc_stack[calc_depth-2]);
                neg = (l < 0) != (r < 0);
                ml = (l < 0) ? -l : l;
                mr = (r < 0) ? -r : r;
                if (item.cmd == CMD_DIV && r == 0)
                    st = ST_DIVZERO;
                else
                begin
                    case (item.cmd)
                        CMD_ADD: v = l + r;
                        CMD_SUB: v = l - r;
                        CMD_MUL: v = (ml * mr) >> 16;
                        default: v = (ml << 16) / mr;
                    endcase
                    if ((item.cmd == CMD_MUL || item.cmd == CMD_DIV) && neg)
                        v = -v;
                    res = clamp_q(v, sat);
                    calc_depth--;
                    calc_stack[calc_depth-1] = res;
                    if (sat)
                        st = ST_SAT;
                end
            end
        end
        o.top_value = calc_depth ? calc_stack[calc_depth-1] : 32'd0;
        o.depth = calc_depth[4:0];
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom_range(0, 8) << 16;
            4: return -($urandom_range(0, 8) << 16);
            5: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic [2:0] cmd, input logic [31:0] val);
        in_item_t it;
        it.cmd = cmd;
        it.operand = val;
        pending_items.push_back(it);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || in_accepted)
        begin
            if (!hold_sender && pending_items.size() > 0 && send_gap == 0
                && !(pending_items[0].cmd == CMD_SPARE_B && expected_results.size() > 0))
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_accepted = 1'b0;
                send_gap = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
                in_accepted = 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
        if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap--;
        end
        else
        begin
            out_stall <= 1'b0;
            recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(calc_step(in_data));
                in_accepted = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected item", out_data.top_value, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.top_value !== want.top_value)
                        report_mismatch("top_value", out_data.top_value, want.top_value);
                    if (out_data.depth !== want.depth)
                        report_mismatch("depth", 32'(out_data.depth), 32'(want.depth));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status), 32'(want.status));
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[stack_calculator_alu_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_sender = 1'b0;
        in_accepted = 1'b0;
        calc_depth = 0;
        for (i = 0; i < DEPTH_MAX; i++)
            calc_stack[i] = '0;

        add_item(CMD_ADD, 32'hFFFF_FFFF);
        add_item(CMD_ROOT, 32'd0);
        add_item(CMD_PUSH, 32'h7FFF_FFFF);
        add_item(CMD_SUB, 32'd0);
        add_item(CMD_PUSH, 32'h7FFF_FFFF);
        add_item(CMD_ADD, 32'd0);
        add_item(CMD_PUSH, 32'h8000_0000);
        add_item(CMD_MUL, 32'd0);
        add_item(CMD_PUSH, 32'd0);
        add_item(CMD_DIV, 32'd0);
        add_item(CMD_ROOT, 32'd0);
        add_item(CMD_PUSH, 32'hFFFF_0000);
        add_item(CMD_ROOT, 32'd0);
        add_item(CMD_PUSH, 32'h0000_8000);
        add_item(CMD_DIV, 32'd0);
        add_item(CMD_SPARE_A, 32'h1234_5678);
        add_item(CMD_SPARE_B, 32'hFFFF_FFFF);
        for (i = 0; i < 8; i++)
            add_item(CMD_PUSH, $urandom);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() > 0 || in_valid)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;

        n = 0;
        while (n < 320)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_item(CMD_PUSH, pick_value());
                4: add_item(CMD_ADD, $urandom);
                5: add_item(CMD_SUB, $urandom);
                6: add_item(CMD_MUL, $urandom);
                7: add_item(CMD_DIV, $urandom);
                8: add_item(CMD_ROOT, $urandom);
                default: add_item(3'($urandom_range(0, 7)), $urandom);
            endcase
            n++;
            if (n % 100 == 0)
                for (i = 0; i < 18; i++)
                    add_item(CMD_PUSH, pick_value());
        end

        while (pending_items.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("[stack_calculator_alu_core] OK");
        else
            $display("[stack_calculator_alu_core] ERROR");
        $finish;
    end

endmodule

// ===== stack_calculator_alu_core.f =====
rtl/sca_pkg.sv
rtl/stack_calculator_alu_core.sv
bench/stack_calculator_alu_core_tb.sv
